// File: hw/rtl/lts_pkg.sv
`timescale 1ns / 1ps

package lts_pkg;

    // Key, stamp, slot and entry widths
    localparam int KEY_W   = 16;
    localparam int STAMP_W = 32;
    localparam int SLOT_W  = 6;
    localparam int ENTRY_W = 2 * KEY_W + STAMP_W;

    // Operation codes carried in the kind field
    typedef enum logic [1:0] {
        KIND_ALLOC   = 2'd0,
        KIND_LOOKUP  = 2'd1,
        KIND_FRESHEN = 2'd2,
        KIND_REMOVE  = 2'd3
    } kind_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } state_t;

    // Sequencer to scan unit
    typedef struct packed {
        logic start;   // new word accepted, reset trackers
        logic valid;   // entry data on the read port is live
    } scan_ctrl_t;

    // Scan unit status back to the sequencer
    typedef struct packed {
        logic empty_found;
        logic match_found;
        logic match_now;   // entry under compare matches the key
    } scan_flags_t;

endpackage

// File: hw/rtl/lts_scan.sv
`timescale 1ns / 1ps

module lts_scan #(
    parameter int IW = 6
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lts_pkg::scan_ctrl_t           ctrl,
    input  logic [IW-1:0]                 idx,
    input  logic [lts_pkg::KEY_W-1:0]     ent_owner,
    input  logic [lts_pkg::KEY_W-1:0]     ent_block,
    input  logic [lts_pkg::STAMP_W-1:0]   ent_stamp,
    input  logic [lts_pkg::KEY_W-1:0]     key_owner,
    input  logic [lts_pkg::KEY_W-1:0]     key_block,
    output lts_pkg::scan_flags_t          flags,
    output logic [IW-1:0]                 empty_idx,
    output logic [IW-1:0]                 match_idx,
    output logic [IW-1:0]                 best_idx,
    output logic [lts_pkg::KEY_W-1:0]     best_owner,
    output logic [lts_pkg::KEY_W-1:0]     best_block
);

    logic                          empty_found_reg, empty_found_next;
    logic                          match_found_reg, match_found_next;
    logic                          have_best_reg, have_best_next;
    logic [IW-1:0]                 empty_idx_reg, empty_idx_next;
    logic [IW-1:0]                 match_idx_reg, match_idx_next;
    logic [IW-1:0]                 best_idx_reg, best_idx_next;
    logic [lts_pkg::STAMP_W-1:0]   best_stamp_reg, best_stamp_next;
    logic [lts_pkg::KEY_W-1:0]     best_owner_reg, best_owner_next;
    logic [lts_pkg::KEY_W-1:0]     best_block_reg, best_block_next;
    logic                          is_empty;
    logic                          is_match;
    logic                          is_older;

    // One entry compared per cycle
    assign is_empty = (ent_owner == '0);
    assign is_match = (key_owner != '0) && (ent_owner == key_owner)
                      && (ent_block == key_block);
    assign is_older = !have_best_reg || (ent_stamp < best_stamp_reg);

    // Tracker update: first empty, first match, oldest stamp (first on tie)
    always_comb
    begin
        empty_found_next = empty_found_reg;
        match_found_next = match_found_reg;
        have_best_next   = have_best_reg;
        empty_idx_next   = empty_idx_reg;
        match_idx_next   = match_idx_reg;
        best_idx_next    = best_idx_reg;
        best_stamp_next  = best_stamp_reg;
        best_owner_next  = best_owner_reg;
        best_block_next  = best_block_reg;
        if (ctrl.start)
        begin
            empty_found_next = 1'b0;
            match_found_next = 1'b0;
            have_best_next   = 1'b0;
            match_idx_next   = '0;
        end
        else if (ctrl.valid)
        begin
            if (is_empty && !empty_found_reg)
            begin
                empty_found_next = 1'b1;
                empty_idx_next   = idx;
            end
            if (is_match && !match_found_reg)
            begin
                match_found_next = 1'b1;
                match_idx_next   = idx;
            end
            if (is_older)
            begin
                have_best_next  = 1'b1;
                best_idx_next   = idx;
                best_stamp_next = ent_stamp;
                best_owner_next = ent_owner;
                best_block_next = ent_block;
            end
        end
    end

    // Control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            empty_found_reg <= 1'b0;
            match_found_reg <= 1'b0;
            have_best_reg   <= 1'b0;
        end
        else
        begin
            empty_found_reg <= empty_found_next;
            match_found_reg <= match_found_next;
            have_best_reg   <= have_best_next;
        end
    end

    // Tracked indices and keys
    always_ff @(posedge clk)
    begin
        empty_idx_reg  <= empty_idx_next;
        match_idx_reg  <= match_idx_next;
        best_idx_reg   <= best_idx_next;
        best_stamp_reg <= best_stamp_next;
        best_owner_reg <= best_owner_next;
        best_block_reg <= best_block_next;
    end

    assign flags.empty_found = empty_found_reg;
    assign flags.match_found = match_found_reg;
    assign flags.match_now   = ctrl.valid && is_match;
    assign empty_idx  = empty_idx_reg;
    assign match_idx  = match_idx_reg;
    assign best_idx   = best_idx_reg;
    assign best_owner = best_owner_reg;
    assign best_block = best_block_reg;

endmodule

// File: hw/rtl/lru_tagged_slot_cache.sv
`timescale 1ns / 1ps
// Channel  | handshake            | payload
// ---------+----------------------+---------------------------------------------
// request  | req_valid, req_stall | kind, is_2d, owner, block
// response | rsp_valid, rsp_stall | hit, slot, evicted, evicted_owner,
//          |                      | evicted_block
//
// Each word goes from accept to the next accept through the accept step, one
// read of the entry memory per slot, a step for the read latency, then an
// update step for the write-back; no new word is taken before its update is done.
// After reset a clearing pass zeroes every word of the entry memory, with
// req_stall high. req_stall is high while a word is in its scan or update
// state; the update waits while an earlier response is still stalled.

module lru_tagged_slot_cache #(
    parameter int SLOTS = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  logic [1:0]                    kind,
    input  logic                          is_2d,
    input  logic [lts_pkg::KEY_W-1:0]     owner,
    input  logic [lts_pkg::KEY_W-1:0]     block,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output logic                          hit,
    output logic [lts_pkg::SLOT_W-1:0]    slot,
    output logic                          evicted,
    output logic [lts_pkg::KEY_W-1:0]     evicted_owner,
    output logic [lts_pkg::KEY_W-1:0]     evicted_block
);

    localparam int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int AW    = IW + 1;
    localparam int DEPTH = 2 ** AW;
    localparam int CW    = $clog2(SLOTS + 1);
    localparam int KW    = lts_pkg::KEY_W;
    localparam int SW    = lts_pkg::STAMP_W;
    localparam int EW    = lts_pkg::ENTRY_W;

    lts_pkg::state_t     state_reg, state_next;
    lts_pkg::kind_t      kind_reg;
    logic                tbl_reg;
    logic [KW-1:0]       own_reg;
    logic [KW-1:0]       blk_reg;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [AW-1:0]       clr_reg, clr_next;
    logic                pv_reg, pv_next;
    logic [IW-1:0]       pidx_reg, pidx_next;
    logic [SW-1:0]       ctr_reg, ctr_next;
    logic                accept;
    logic                rsp_free;

    // Entry memory, one word per slot in each of two tables (is_2d selects): owner, block, stamp
    logic [EW-1:0]       mem [DEPTH];
    logic [EW-1:0]       rd_data_reg;
    logic                mem_re;
    logic [AW-1:0]       mem_raddr;
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [EW-1:0]       mem_wdata;

    // Response register
    logic                rsp_valid_reg, rsp_valid_next;
    logic                hit_reg, hit_next;
    logic [IW-1:0]       slot_idx_reg, slot_idx_next;
    logic                ev_reg, ev_next;
    logic [KW-1:0]       ev_own_reg, ev_own_next;
    logic [KW-1:0]       ev_blk_reg, ev_blk_next;

    // Scan unit
    lts_pkg::scan_ctrl_t  sc_ctrl;
    lts_pkg::scan_flags_t sc_flags;
    logic [IW-1:0]        sc_empty_idx;
    logic [IW-1:0]        sc_match_idx;
    logic [IW-1:0]        sc_best_idx;
    logic [KW-1:0]        sc_best_owner;
    logic [KW-1:0]        sc_best_block;

    assign accept    = req_valid && !req_stall;
    assign req_stall = (state_reg != lts_pkg::ST_IDLE);
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;

    assign sc_ctrl.start = accept;
    assign sc_ctrl.valid = pv_reg;

    lts_scan #(
        .IW (IW)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (sc_ctrl),
        .idx        (pidx_reg),
        .ent_owner  (rd_data_reg[EW-1 -: KW]),
        .ent_block  (rd_data_reg[SW +: KW]),
        .ent_stamp  (rd_data_reg[SW-1:0]),
        .key_owner  (own_reg),
        .key_block  (blk_reg),
        .flags      (sc_flags),
        .empty_idx  (sc_empty_idx),
        .match_idx  (sc_match_idx),
        .best_idx   (sc_best_idx),
        .best_owner (sc_best_owner),
        .best_block (sc_best_block)
    );

    // Sequencer: clear, idle, scan one slot per cycle, update and respond
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        clr_next       = clr_reg;
        pv_next        = 1'b0;
        pidx_next      = cnt_reg[IW-1:0];
        ctr_next       = ctr_reg;
        mem_re         = 1'b0;
        mem_raddr      = {tbl_reg, cnt_reg[IW-1:0]};
        mem_we         = 1'b0;
        mem_waddr      = {tbl_reg, pidx_reg};
        mem_wdata      = '0;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        hit_next       = hit_reg;
        slot_idx_next  = slot_idx_reg;
        ev_next        = ev_reg;
        ev_own_next    = ev_own_reg;
        ev_blk_next    = ev_blk_reg;
        unique case (state_reg)
            lts_pkg::ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == '1)
                begin
                    state_next = lts_pkg::ST_IDLE;
                end
            end
            lts_pkg::ST_IDLE:
            begin
                cnt_next = '0;
                if (accept)
                begin
                    state_next = lts_pkg::ST_SCAN;
                end
            end
            lts_pkg::ST_SCAN:
            begin
                // issue next read
                if (cnt_reg != CW'(SLOTS))
                begin
                    mem_re   = 1'b1;
                    pv_next  = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                end
                else
                begin
                    state_next = lts_pkg::ST_UPDATE;
                end
                // remove clears matches as they stream by
                if (kind_reg == lts_pkg::KIND_REMOVE && sc_flags.match_now)
                begin
                    mem_we = 1'b1;
                end
            end
            lts_pkg::ST_UPDATE:
            begin
                if (rsp_free)
                begin
                    state_next     = lts_pkg::ST_IDLE;
                    rsp_valid_next = 1'b1;
                    hit_next       = sc_flags.match_found;
                    slot_idx_next  = sc_flags.match_found ? sc_match_idx : '0;
                    ev_next        = 1'b0;
                    ev_own_next    = '0;
                    ev_blk_next    = '0;
                    mem_wdata      = {own_reg, blk_reg, ctr_reg};
                    case (kind_reg)
                        lts_pkg::KIND_ALLOC:
                        begin
                            hit_next  = 1'b1;
                            mem_we    = 1'b1;
                            ctr_next  = ctr_reg + 1'b1;
                            if (sc_flags.empty_found)
                            begin
                                slot_idx_next = sc_empty_idx;
                            end
                            else
                            begin
                                slot_idx_next = sc_best_idx;
                                ev_next       = 1'b1;
                                ev_own_next   = sc_best_owner;
                                ev_blk_next   = sc_best_block;
                            end
                            mem_waddr = {tbl_reg, slot_idx_next};
                        end
                        lts_pkg::KIND_FRESHEN:
                        begin
                            mem_waddr = {tbl_reg, sc_match_idx};
                            if (sc_flags.match_found)
                            begin
                                mem_we   = 1'b1;
                                ctr_next = ctr_reg + 1'b1;
                            end
                        end
                        default:
                        begin
                            mem_we = 1'b0;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = lts_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lts_pkg::ST_CLEAR;
            cnt_reg       <= '0;
            clr_reg       <= '0;
            pv_reg        <= 1'b0;
            ctr_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            clr_reg       <= clr_next;
            pv_reg        <= pv_next;
            ctr_reg       <= ctr_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Request word and response payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= lts_pkg::kind_t'(kind);
            tbl_reg  <= is_2d;
            own_reg  <= owner;
            blk_reg  <= block;
        end
        pidx_reg     <= pidx_next;
        hit_reg      <= hit_next;
        slot_idx_reg <= slot_idx_next;
        ev_reg       <= ev_next;
        ev_own_reg   <= ev_own_next;
        ev_blk_reg   <= ev_blk_next;
    end

    // Entry memory ports
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    assign rsp_valid     = rsp_valid_reg;
    assign hit           = hit_reg;
    assign slot          = lts_pkg::SLOT_W'(slot_idx_reg);
    assign evicted       = ev_reg;
    assign evicted_owner = ev_own_reg;
    assign evicted_block = ev_blk_reg;

    // Use counter moves only on the update cycle
    a_ctr_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != lts_pkg::ST_UPDATE) |=> (ctr_reg == $past(ctr_reg)))
        else $error("use counter changed outside update");

    // An accepted word starts a scan
    a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == lts_pkg::ST_SCAN))
        else $error("accepted word did not start a scan");

    // Scan writes only for remove
    a_scan_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lts_pkg::ST_SCAN && mem_we) |->
        (kind_reg == lts_pkg::KIND_REMOVE))
        else $error("memory write during scan of non-remove word");

    // A taken response is not repeated
    a_rsp_once: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && !rsp_stall && state_reg != lts_pkg::ST_UPDATE)
        |=> !rsp_valid_reg)
        else $error("response repeated");

endmodule
